FILE: rtl/fgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fgc_pkg;

  // field widths
  localparam int unsigned SizeW    = 25;
  localparam int unsigned CountW   = 16;
  localparam int unsigned GeoW     = 8;
  localparam int unsigned SpcW     = 4;
  localparam int unsigned RootW    = 10;
  localparam int unsigned FatW     = 8;

  // datapath widths
  localparam int unsigned SectorShift = 9;
  localparam int unsigned SqW         = 2 * (GeoW + 1);
  localparam int unsigned ProdW       = SqW + GeoW + 1;
  localparam int unsigned StepW       = 4;

  // thresholds and fixed values
  localparam logic [SizeW-1:0]  RootSizeLimit   = 25'h008C000;
  localparam logic [RootW-1:0]  RootSmall       = 10'h020;
  localparam logic [RootW-1:0]  RootLarge       = 10'h200;
  localparam logic [CountW-1:0] BigClusterLimit = 16'(8 << 10);
  localparam logic [CountW-1:0] MidClusterLimit = 16'(1 << 10);

  // program addresses
  localparam logic [StepW-1:0] S_IDLE   = 4'd0;
  localparam logic [StepW-1:0] S_LSQ    = 4'd1;
  localparam logic [StepW-1:0] S_LPR    = 4'd2;
  localparam logic [StepW-1:0] S_LGROW  = 4'd3;
  localparam logic [StepW-1:0] S_TSQ    = 4'd4;
  localparam logic [StepW-1:0] S_TPR    = 4'd5;
  localparam logic [StepW-1:0] S_TFIT   = 4'd6;
  localparam logic [StepW-1:0] S_LOOP   = 4'd7;
  localparam logic [StepW-1:0] S_FSQ    = 4'd8;
  localparam logic [StepW-1:0] S_FPR    = 4'd9;
  localparam logic [StepW-1:0] S_FTRK   = 4'd10;
  localparam logic [StepW-1:0] S_SPC    = 4'd11;
  localparam logic [StepW-1:0] S_FAT    = 4'd12;
  localparam logic [StepW-1:0] S_OUT    = 4'd13;

  typedef enum logic [1:0] {
    SQ_NONE,
    SQ_INC,
    SQ_CUR
  } sq_op_e;

  typedef enum logic [1:0] {
    PR_NONE,
    PR_TRK,
    PR_TRK1
  } pr_op_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_LOAD,
    UPD_GROW,
    UPD_COUNT,
    UPD_TRACK,
    UPD_SPC,
    UPD_FAT,
    UPD_OUT
  } upd_op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_OVER,
    JC_WAIT_IN,
    JC_WAIT_OUT
  } jmp_op_e;

  typedef struct packed {
    sq_op_e             sq;
    pr_op_e             pr;
    upd_op_e            upd;
    logic               upd_fit;
    jmp_op_e            jmp;
    logic [StepW-1:0]   target;
  } ctrl_word_t;

  // control store
  function automatic ctrl_word_t ctrl_rom(input logic [StepW-1:0] step);
    ctrl_word_t w;
    w = '{sq: SQ_NONE, pr: PR_NONE, upd: UPD_NONE, upd_fit: 1'b0,
          jmp: JC_ALWAYS, target: S_IDLE};
    case (step)
      S_IDLE:  begin w.upd = UPD_LOAD; w.jmp = JC_WAIT_IN; end
      S_LSQ:   begin w.sq = SQ_INC; w.jmp = JC_NEXT; end
      S_LPR:   begin w.pr = PR_TRK; w.jmp = JC_NEXT; end
      S_LGROW: begin
        w.upd = UPD_GROW; w.upd_fit = 1'b1; w.jmp = JC_OVER; w.target = S_FSQ;
      end
      S_TSQ:   begin w.sq = SQ_CUR; w.jmp = JC_NEXT; end
      S_TPR:   begin w.pr = PR_TRK; w.jmp = JC_NEXT; end
      S_TFIT:  begin
        w.upd = UPD_COUNT; w.upd_fit = 1'b1; w.jmp = JC_OVER; w.target = S_FSQ;
      end
      S_LOOP:  begin w.jmp = JC_ALWAYS; w.target = S_LSQ; end
      S_FSQ:   begin w.sq = SQ_CUR; w.jmp = JC_NEXT; end
      S_FPR:   begin w.pr = PR_TRK1; w.jmp = JC_NEXT; end
      S_FTRK:  begin w.upd = UPD_TRACK; w.upd_fit = 1'b1; w.jmp = JC_NEXT; end
      S_SPC:   begin w.upd = UPD_SPC; w.jmp = JC_NEXT; end
      S_FAT:   begin w.upd = UPD_FAT; w.jmp = JC_NEXT; end
      S_OUT:   begin w.upd = UPD_OUT; w.jmp = JC_WAIT_OUT; w.target = S_IDLE; end
      default: begin w.jmp = JC_ALWAYS; w.target = S_IDLE; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fgc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// size channel
interface fgc_in_if import fgc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SizeW-1:0] size_bytes;

  modport source (output valid, output size_bytes, input ready);
  modport sink   (input valid, input size_bytes, output ready);
endinterface

// geometry channel
interface fgc_out_if import fgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] sector_count;
  logic [GeoW-1:0]   sectors_per_track;
  logic [GeoW-1:0]   head_count;
  logic [SpcW-1:0]   sectors_per_cluster;
  logic [RootW-1:0]  root_entry_count;
  logic [CountW-1:0] cluster_count;
  logic [FatW-1:0]   fat_sectors;

  modport source (output valid, output sector_count, output sectors_per_track,
                  output head_count, output sectors_per_cluster,
                  output root_entry_count, output cluster_count,
                  output fat_sectors, input ready);
  modport sink   (input valid, input sector_count, input sectors_per_track,
                  input head_count, input sectors_per_cluster,
                  input root_entry_count, input cluster_count,
                  input fat_sectors, output ready);
endinterface

`default_nettype wire

FILE: rtl/fat12_geometry_calc_top.sv
`timescale 1ns / 1ps
`default_nettype none

// FAT12 volume geometry from a storage size in bytes.
// in_i carries one item per volume: size_bytes. out_o returns one item per
// input: sector count, sectors per track, heads, sectors per cluster, root
// entries, cluster count and FAT sectors.
// A short microprogram in a control store steps a datapath with a squarer
// and a multiplier: each pass of the head/track search takes seven steps
// (square, product, compare and update, twice, then the loop jump).
// After the loop, the last track step (square, product, update) and the
// cluster, FAT and output steps follow.
// One item is worked on at a time: in_i.ready is high only while the
// sequencer waits at its idle step, so no new item is taken before the
// last one's result has reached the output register.
// Results sit in an output register; if it still holds a result and
// out_o.ready is low, the sequencer holds its last step until the register
// is free, and the next item is taken as soon as the result has been moved
// to the register.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties
// the output register; no clearing pass is needed.

module fat12_geometry_calc_top import fgc_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  fgc_in_if.sink    in_i,
  fgc_out_if.source out_o
);

  logic [StepW-1:0]  step_q, step_d;
  logic              out_valid_q, out_valid_d;
  ctrl_word_t        cw;

  logic [CountW-1:0] limit_q;
  logic              root_large_q;
  logic [GeoW-1:0]   trk_q;
  logic [GeoW-1:0]   heads_q;
  logic [CountW-1:0] count_q;
  logic [SqW-1:0]    sq_q;
  logic [ProdW-1:0]  prod_q;
  logic [SpcW-1:0]   spc_q;
  logic [CountW-1:0] clusters_q;
  logic [FatW-1:0]   fat_q;

  logic              in_acc;
  logic              slot_free;
  logic              over;
  logic              do_upd;
  logic [GeoW:0]     sq_base;
  logic [GeoW:0]     pr_base;

  // cluster and fat arithmetic
  logic [1:0]        cl_shift;
  logic [SpcW-1:0]   spc_new;
  logic [CountW:0]   cl_sum;
  logic [CountW:0]   cl_shifted;
  logic [CountW:0]   half_sum;
  logic [CountW+1:0] fat_bytes;
  logic [CountW+1:0] fat_sum;

  assign cw        = ctrl_rom(step_q);
  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign over      = prod_q > {{(ProdW-CountW){1'b0}}, limit_q};
  assign do_upd    = !cw.upd_fit || !over;

  assign in_i.ready = (step_q == S_IDLE);

  // multiplier operands
  always_comb begin
    sq_base = {1'b0, heads_q};
    if (cw.sq == SQ_INC) sq_base = {1'b0, heads_q} + {{GeoW{1'b0}}, 1'b1};
    pr_base = {1'b0, trk_q};
    if (cw.pr == PR_TRK1) pr_base = {1'b0, trk_q} + {{GeoW{1'b0}}, 1'b1};
  end

  // cluster size and rounding
  always_comb begin
    if (count_q > BigClusterLimit) begin
      spc_new  = 4'd8;
      cl_shift = 2'd3;
    end else if (count_q > MidClusterLimit) begin
      spc_new  = 4'd4;
      cl_shift = 2'd2;
    end else begin
      spc_new  = 4'd1;
      cl_shift = 2'd0;
    end
    cl_sum     = {1'b0, count_q} + {{(CountW+1-SpcW){1'b0}}, spc_new - 4'd1};
    cl_shifted = cl_sum >> cl_shift;
    half_sum   = {1'b0, clusters_q} + {{CountW{1'b0}}, 1'b1};
    fat_bytes  = {2'b00, half_sum[CountW:1]} + {1'b0, half_sum[CountW:1], 1'b0};
    fat_sum    = fat_bytes + (CountW+2)'(511);
  end

  // step counter and jumps
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    case (cw.jmp)
      JC_NEXT:     step_d = step_q + 4'd1;
      JC_ALWAYS:   step_d = cw.target;
      JC_OVER:     step_d = over ? cw.target : step_q + 4'd1;
      JC_WAIT_IN:  if (in_acc) step_d = step_q + 4'd1;
      JC_WAIT_OUT: begin
        if (slot_free) begin
          step_d      = cw.target;
          out_valid_d = 1'b1;
        end
      end
      default:     step_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (cw.sq != SQ_NONE) sq_q <= SqW'(sq_base) * SqW'(sq_base);
    if (cw.pr != PR_NONE) prod_q <= ProdW'(pr_base) * ProdW'(sq_q);
    case (cw.upd)
      UPD_LOAD: begin
        if (in_acc) begin
          limit_q      <= in_i.size_bytes[SizeW-1:SectorShift];
          root_large_q <= !(in_i.size_bytes < RootSizeLimit);
          trk_q        <= GeoW'(1);
          heads_q      <= GeoW'(1);
          count_q      <= CountW'(1);
        end
      end
      UPD_GROW: begin
        if (do_upd) begin
          heads_q <= heads_q + GeoW'(1);
          trk_q   <= trk_q + GeoW'(1);
          count_q <= prod_q[CountW-1:0];
        end
      end
      UPD_COUNT: begin
        if (do_upd) count_q <= prod_q[CountW-1:0];
      end
      UPD_TRACK: begin
        if (do_upd) begin
          trk_q   <= trk_q + GeoW'(1);
          count_q <= prod_q[CountW-1:0];
        end
      end
      UPD_SPC: begin
        spc_q      <= spc_new;
        clusters_q <= cl_shifted[CountW-1:0];
      end
      UPD_FAT: fat_q <= fat_sum[SectorShift+FatW-1:SectorShift];
      UPD_OUT: begin
        if (slot_free) begin
          out_o.sector_count        <= count_q;
          out_o.sectors_per_track   <= trk_q;
          out_o.head_count          <= heads_q;
          out_o.sectors_per_cluster <= spc_q;
          out_o.root_entry_count    <= root_large_q ? RootLarge : RootSmall;
          out_o.cluster_count       <= clusters_q;
          out_o.fat_sectors         <= fat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;

  // checks
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> step_q == S_LSQ)
    else $error("sequencer did not start after input item");

  a_trk_ge_heads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != S_IDLE) |-> trk_q >= heads_q)
    else $error("track count fell below head count");

  a_count_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != S_IDLE) |-> (count_q <= limit_q || count_q == CountW'(1)))
    else $error("sector count exceeds usable sectors");

  a_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_OUT && slot_free) |=> (out_o.valid && step_q == S_IDLE))
    else $error("result not moved to output register");

endmodule

`default_nettype wire
